FILE: rtl/bgp_session_hold_timer_table_core_defines.svh
// assertion macros for the session hold timer table
`ifndef BGP_SESSION_HOLD_TIMER_TABLE_CORE_DEFINES_SVH
`define BGP_SESSION_HOLD_TIMER_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BSHT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define BSHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bsht_pkg.sv
// types and codes shared by the session hold timer table
`timescale 1ns / 1ps
`default_nettype none
package bsht_pkg;

  // operation codes
  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_KEEP  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // event kinds
  localparam logic [1:0] EV_START   = 2'd0;
  localparam logic [1:0] EV_CLOSE   = 2'd1;
  localparam logic [1:0] EV_TIMEOUT = 2'd2;
  localparam logic [1:0] EV_DROP    = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] flow_key;
    logic        direction;
    logic [15:0] peer_asn;
    logic [15:0] peer_hold_time;
    logic [31:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] opener_asn;
    logic [15:0] answer_asn;
    logic [15:0] source_hold;
    logic [15:0] destination_hold;
    logic [31:0] event_seconds;
    logic        last_of_run;
  } evt_t;

  // entry fields read out through the chain
  typedef struct packed {
    logic [15:0] src_asn;
    logic [15:0] dst_asn;
    logic [15:0] src_hold;
    logic [15:0] dst_hold;
  } entry_t;

  // broadcast command to every cell
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CREATE,
    CMD_SET_DST,
    CMD_HEARD,
    CMD_CLOSE,
    CMD_LOAD,
    CMD_EXPIRE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_pend;
    item_t    item;
  } cell_cmd_t;

  // link passed from one cell to the next
  typedef struct packed {
    logic   hit_seen;
    logic   free_seen;
    logic   pend_seen;
    logic   pend_two;
    entry_t data;
  } chain_t;

endpackage
`default_nettype wire

FILE: rtl/bsht_cell.sv
// one table entry with its match, free and expiry links
`timescale 1ns / 1ps
`default_nettype none
module bsht_cell
  import bsht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_cmd_t cmd,
  input  wire chain_t    chain_i,
  output chain_t         chain_o
);

  logic        valid;
  logic        pend;
  logic [63:0] key;
  entry_t      ent;
  logic [31:0] src_heard;
  logic [31:0] dst_heard;

  logic hit, hit_first, free_first, pend_first, rd_sel, expired;
  logic [32:0] src_lim, dst_lim, now_ext;

  // first-match priority along the row
  always_comb begin
    hit        = valid && (key == cmd.item.flow_key);
    hit_first  = hit && !chain_i.hit_seen;
    free_first = !valid && !chain_i.free_seen;
    pend_first = pend && !chain_i.pend_seen;
    rd_sel     = cmd.rd_pend ? pend_first : hit_first;
    src_lim    = {1'b0, src_heard} + {17'd0, ent.src_hold};
    dst_lim    = {1'b0, dst_heard} + {17'd0, ent.dst_hold};
    now_ext    = {1'b0, cmd.item.now_seconds};
    expired    = (now_ext > src_lim) || (now_ext > dst_lim);
  end

  // hand links to the next cell
  always_comb begin
    chain_o.hit_seen  = chain_i.hit_seen | hit;
    chain_o.free_seen = chain_i.free_seen | !valid;
    chain_o.pend_seen = chain_i.pend_seen | pend;
    chain_o.pend_two  = chain_i.pend_two | (pend && chain_i.pend_seen);
    chain_o.data      = chain_i.data | (rd_sel ? ent : '0);
  end

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pend  <= 1'b0;
    end else begin
      unique case (cmd.op)
        CMD_CREATE: if (free_first) valid <= 1'b1;
        CMD_CLOSE:  if (hit_first) valid <= 1'b0;
        CMD_LOAD:   pend <= valid && expired;
        CMD_EXPIRE: if (pend_first) begin
          valid <= 1'b0;
          pend  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_CREATE: if (free_first) begin
        key          <= cmd.item.flow_key;
        ent.src_asn  <= cmd.item.peer_asn;
        ent.src_hold <= cmd.item.peer_hold_time;
        ent.dst_asn  <= '0;
        ent.dst_hold <= '0;
        src_heard    <= cmd.item.now_seconds;
        dst_heard    <= cmd.item.now_seconds;
      end
      CMD_SET_DST: if (hit_first) begin
        ent.dst_asn  <= cmd.item.peer_asn;
        ent.dst_hold <= cmd.item.peer_hold_time;
      end
      CMD_HEARD: if (hit_first) begin
        if (cmd.item.direction) dst_heard <= cmd.item.now_seconds;
        else src_heard <= cmd.item.now_seconds;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/bgp_session_hold_timer_table_core.sv
// Session hold timer table: a row of entry cells under a small sequencer.
// Open, keepalive and close go from idle through one row lookup state
// back to idle, plus any wait for a free output slot. A tick loads
// expiry flags, then sweeps one timeout per expired entry out through
// the single output register. Synchronous reset clears all valid bits.
`timescale 1ns / 1ps
`default_nettype none
module bgp_session_hold_timer_table_core
  import bsht_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_ready,
  input  wire item_t item,
  output logic       evt_valid,
  input  wire logic  evt_ready,
  output evt_t       evt
);
  `include "bgp_session_hold_timer_table_core_defines.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SWEEP} state_t;

  state_t    state;
  item_t     item_q;
  cell_cmd_t cmd;
  chain_t    links [TABLE_ENTRIES+1];
  chain_t    tail;
  evt_t      evt_next;
  logic      emit, done, slot_free;

  assign links[0]   = '0;
  assign tail       = links[TABLE_ENTRIES];
  assign item_ready = (state == ST_IDLE);
  assign slot_free  = !evt_valid || evt_ready;

  // row of entry cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    bsht_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .chain_i (links[i]),
      .chain_o (links[i+1])
    );
  end

  // command and result selection
  always_comb begin
    cmd.op      = CMD_NONE;
    cmd.rd_pend = (state == ST_SWEEP);
    cmd.item    = item_q;
    emit        = 1'b0;
    done        = 1'b0;
    evt_next.event_kind       = EV_START;
    evt_next.opener_asn       = tail.data.src_asn;
    evt_next.answer_asn       = tail.data.dst_asn;
    evt_next.source_hold      = tail.data.src_hold;
    evt_next.destination_hold = tail.data.dst_hold;
    evt_next.event_seconds    = item_q.now_seconds;
    evt_next.last_of_run      = 1'b1;
    unique case (state)
      ST_EXEC: begin
        unique case (item_q.operation)
          OP_OPEN: begin
            if (tail.hit_seen) begin
              evt_next.answer_asn       = item_q.peer_asn;
              evt_next.destination_hold = item_q.peer_hold_time;
              if (slot_free) begin
                cmd.op = CMD_SET_DST;
                emit   = 1'b1;
                done   = 1'b1;
              end
            end else if (tail.free_seen) begin
              cmd.op = CMD_CREATE;
              done   = 1'b1;
            end else begin
              evt_next.event_kind       = EV_DROP;
              evt_next.opener_asn       = item_q.peer_asn;
              evt_next.source_hold      = item_q.peer_hold_time;
              evt_next.answer_asn       = '0;
              evt_next.destination_hold = '0;
              if (slot_free) begin
                emit = 1'b1;
                done = 1'b1;
              end
            end
          end
          OP_KEEP: begin
            cmd.op = CMD_HEARD;
            done   = 1'b1;
          end
          OP_CLOSE: begin
            evt_next.event_kind = EV_CLOSE;
            if (!tail.hit_seen) begin
              done = 1'b1;
            end else if (slot_free) begin
              cmd.op = CMD_CLOSE;
              emit   = 1'b1;
              done   = 1'b1;
            end
          end
          OP_TICK: begin
            cmd.op = CMD_LOAD;
          end
          default: ;
        endcase
      end
      ST_SWEEP: begin
        evt_next.event_kind  = EV_TIMEOUT;
        evt_next.last_of_run = !tail.pend_two;
        if (!tail.pend_seen) begin
          done = 1'b1;
        end else if (slot_free) begin
          cmd.op = CMD_EXPIRE;
          emit   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      evt_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (item_valid) state <= ST_EXEC;
        ST_EXEC: begin
          if (item_q.operation == OP_TICK) state <= ST_SWEEP;
          else if (done) state <= ST_IDLE;
        end
        ST_SWEEP: if (done) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (emit) evt_valid <= 1'b1;
      else if (evt_ready) evt_valid <= 1'b0;
      if (emit) evt <= evt_next;
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) item_q <= item;
  end

  `BSHT_ASSERT_NEXT(a_accept_exec, item_valid && item_ready, state == ST_EXEC, "no lookup")
  `BSHT_ASSERT_NEXT(a_tick_sweep, state == ST_EXEC && item_q.operation == OP_TICK, state == ST_SWEEP, "no sweep")
  `BSHT_ASSERT_NEXT(a_sweep_end, state == ST_SWEEP && !tail.pend_seen, state == ST_IDLE, "sweep stuck")
  `BSHT_ASSERT_SAME(a_create_miss, cmd.op == CMD_CREATE, !tail.hit_seen && tail.free_seen, "bad create")

endmodule
`default_nettype wire
